// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on clk, quiet while arst_n is low
`define JDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// field must sit in [lo, hi] whenever the qualifier is high
`define JDC_ASSERT_RANGE(lbl, qual, sig, lo, hi, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		qual |-> (sig >= lo && sig <= hi)) else $error(msg);

`endif

// ===== rtl/jdc_pkg.sv =====
package jdc_pkg;

	localparam int NumStages = 7;

	localparam logic [22:0] SwitchReset = 23'd2299160;
	localparam logic [16:0] SecMax      = 17'd86399;

	// A = floor((4I - 7468865) / 146097), biased by 52 periods to stay positive
	localparam logic [25:0] AOffset = 26'd128179;
	localparam logic signed [9:0] ABias = 10'sd52;
	localparam int ShiftA = 44;
	localparam logic [26:0] RecipA =
		27'(((64'd1 << ShiftA) + 64'd146096) / 64'd146097);

	localparam logic [23:0] CBias = 24'd1524;

	// D = floor((20C - 2442) / 7305)
	localparam logic [27:0] DOffset = 28'd2442;
	localparam int ShiftD = 41;
	localparam logic [28:0] RecipD =
		29'(((64'd1 << ShiftD) + 64'd7304) / 64'd7305);

	localparam logic signed [15:0] YearEarly = 16'sd4715;
	localparam logic signed [15:0] YearLate  = 16'sd4716;

	// year shifted by a multiple of 400 so the century test sees a positive value
	localparam logic signed [15:0] YearBias = 16'sd4800;
	localparam int ShiftCent = 19;
	localparam logic [12:0] RecipCent =
		13'(((64'd1 << ShiftCent) + 64'd99) / 64'd100);

	localparam int ShiftHour = 27;
	localparam logic [15:0] RecipHour =
		16'(((64'd1 << ShiftHour) + 64'd3599) / 64'd3600);

	localparam int ShiftMin = 20;
	localparam logic [14:0] RecipMin =
		15'(((64'd1 << ShiftMin) + 64'd59) / 64'd60);

	typedef struct packed {
		logic [NumStages-1:0] ld;
	} pipe_ctl_t;

	// floor(30.6001 * g)
	function automatic logic [8:0] month_span(input logic [3:0] g);
		logic [8:0] h;
		unique case (g)
			4'd1:    h = 9'd30;
			4'd2:    h = 9'd61;
			4'd3:    h = 9'd91;
			4'd4:    h = 9'd122;
			4'd5:    h = 9'd153;
			4'd6:    h = 9'd183;
			4'd7:    h = 9'd214;
			4'd8:    h = 9'd244;
			4'd9:    h = 9'd275;
			4'd10:   h = 9'd306;
			4'd11:   h = 9'd336;
			4'd12:   h = 9'd367;
			4'd13:   h = 9'd397;
			4'd14:   h = 9'd428;
			4'd15:   h = 9'd459;
			default: h = 9'd0;
		endcase
		return h;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] mon);
		logic [8:0] n;
		unique case (mon)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/jdc_pipe_ctrl.sv =====
module jdc_pipe_ctrl import jdc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output pipe_ctl_t ctl
);

	logic [NumStages-1:0] vld_q;
	logic [NumStages-1:0] ld;

	// a stage loads when empty or when its beat moves on
	always_comb begin
		ld[NumStages-1] = !vld_q[NumStages-1] || out_ready;
		for (int k = NumStages - 2; k >= 0; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NumStages; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = vld_q[NumStages-1];
	assign ctl.ld    = ld;

endmodule

// ===== rtl/jdc_date_path.sv =====
module jdc_date_path import jdc_pkg::*; (
	input  logic               clk,
	input  pipe_ctl_t          ctl,
	input  logic [22:0]        day_number,
	input  logic [22:0]        switch_day,
	output logic signed [14:0] year,
	output logic [3:0]         month,
	output logic [4:0]         day_of_month,
	output logic [8:0]         day_of_year
);

	// stage 1: century correction quotient
	logic [25:0] na;
	logic [52:0] pa;
	logic [22:0] day_s1;
	logic        greg_s1;
	logic [7:0]  qa_s1;

	assign na = {day_number, 2'b00} + AOffset;
	assign pa = 53'(na) * 53'(RecipA);

	always_ff @(posedge clk) begin
		if (ctl.ld[0]) begin
			day_s1  <= day_number;
			greg_s1 <= day_number > switch_day;
			qa_s1   <= pa[ShiftA +: 8];
		end
	end

	// stage 2: C and the numerator of D
	logic signed [9:0] a;
	logic signed [9:0] badj;
	logic [23:0]       c;
	logic [27:0]       nd;
	logic [23:0]       c_s2;
	logic [27:0]       nd_s2;
	logic              greg_s2;

	always_comb begin
		a    = $signed({2'b00, qa_s1}) - ABias;
		badj = 10'sd1 + a - (a >>> 2);
		c    = 24'(day_s1) + CBias + (greg_s1 ? 24'(badj) : 24'd0);
		nd   = ({c, 4'b0000} + {2'b00, c, 2'b00}) - DOffset;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[1]) begin
			c_s2    <= c;
			nd_s2   <= nd;
			greg_s2 <= greg_s1;
		end
	end

	// stage 3: D
	logic [56:0] pd;
	logic [14:0] d_s3;
	logic [23:0] c_s3;
	logic        greg_s3;

	assign pd = 57'(nd_s2) * 57'(RecipD);

	always_ff @(posedge clk) begin
		if (ctl.ld[2]) begin
			d_s3    <= pd[ShiftD +: 15];
			c_s3    <= c_s2;
			greg_s3 <= greg_s2;
		end
	end

	// stage 4: days left in the year window, C - E
	logic [25:0] e26;
	logic [23:0] cx;
	logic [8:0]  x_s4;
	logic [14:0] d_s4;
	logic        greg_s4;

	always_comb begin
		e26 = 26'(d_s3) * 26'd1461;
		cx  = c_s3 - e26[25:2];
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[3]) begin
			x_s4    <= cx[8:0];
			d_s4    <= d_s3;
			greg_s4 <= greg_s3;
		end
	end

	// stage 5: month index G by threshold compare, then month, day and year
	logic [22:0]        xs;
	logic [3:0]         g;
	logic [3:0]         mon;
	logic signed [15:0] yr;
	logic [3:0]         month_s5;
	logic [4:0]         mday_s5;
	logic signed [15:0] year_s5;
	logic               greg_s5;

	always_comb begin
		xs = 23'(x_s4) * 23'd10000;
		g  = 4'd0;
		for (int k = 1; k <= 15; k++) begin
			if (xs >= 23'(k * 306001)) begin
				g = 4'(k);
			end
		end
		mon = (g <= 4'd13) ? g - 4'd1 : g - 4'd13;
		yr  = $signed({1'b0, d_s4}) - ((mon <= 4'd2) ? YearEarly : YearLate);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[4]) begin
			month_s5 <= mon;
			mday_s5  <= 5'(x_s4 - month_span(g));
			year_s5  <= yr;
			greg_s5  <= greg_s4;
		end
	end

	// stage 6: year / 100 on the biased year
	logic [14:0]        yp;
	logic [27:0]        pc;
	logic [14:0]        yp_s6;
	logic [7:0]         q_s6;
	logic [3:0]         month_s6;
	logic [4:0]         mday_s6;
	logic signed [15:0] year_s6;
	logic               greg_s6;

	always_comb begin
		yp = 15'(year_s5 + YearBias);
		pc = 28'(yp) * 28'(RecipCent);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[5]) begin
			yp_s6    <= yp;
			q_s6     <= pc[ShiftCent +: 8];
			month_s6 <= month_s5;
			mday_s6  <= mday_s5;
			year_s6  <= year_s5;
			greg_s6  <= greg_s5;
		end
	end

	// stage 7: leap test and day of year
	logic [14:0] r100;
	logic        leap;
	logic [8:0]  doy;
	logic signed [14:0] year_s7;
	logic [3:0]  month_s7;
	logic [4:0]  mday_s7;
	logic [8:0]  doy_s7;

	always_comb begin
		r100 = yp_s6 - 15'(15'(q_s6) * 15'd100);
		// julian rule is divisible by four; gregorian drops centuries not divisible by 400
		leap = (yp_s6[1:0] == 2'b00) &&
			(!greg_s6 || (r100 != 15'd0) || (q_s6[1:0] == 2'b00));
		doy  = 9'(mday_s6) + days_before(month_s6) +
			9'(leap && (month_s6 > 4'd2));
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[6]) begin
			year_s7  <= year_s6[14:0];
			month_s7 <= month_s6;
			mday_s7  <= mday_s6;
			doy_s7   <= doy;
		end
	end

	assign year         = year_s7;
	assign month        = month_s7;
	assign day_of_month = mday_s7;
	assign day_of_year  = doy_s7;

endmodule

// ===== rtl/jdc_time_path.sv =====
module jdc_time_path import jdc_pkg::*; (
	input  logic        clk,
	input  pipe_ctl_t   ctl,
	input  logic [22:0] day_number,
	input  logic [16:0] seconds_of_day,
	output logic [2:0]  weekday,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	// stage 1: saturate seconds, octal digit sum of day + 1 (8 is 1 mod 7)
	logic [23:0] w;
	logic [5:0]  wsum;
	logic [16:0] sec_s1;
	logic [5:0]  wsum_s1;

	always_comb begin
		w    = 24'(day_number) + 24'd1;
		wsum = '0;
		for (int i = 0; i < 8; i++) begin
			wsum = wsum + 6'(w[3*i +: 3]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[0]) begin
			sec_s1  <= (seconds_of_day > SecMax) ? SecMax : seconds_of_day;
			wsum_s1 <= wsum;
		end
	end

	// stage 2: hour, weekday fold
	logic [32:0] ph;
	logic [3:0]  f1;
	logic [3:0]  f2;
	logic [16:0] sec_s2;
	logic [4:0]  hour_s2;
	logic [2:0]  wday_s2;

	always_comb begin
		ph = 33'(sec_s1) * 33'(RecipHour);
		f1 = 4'(wsum_s1[5:3]) + 4'(wsum_s1[2:0]);
		f2 = 4'(f1[3]) + 4'(f1[2:0]);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[1]) begin
			sec_s2  <= sec_s1;
			hour_s2 <= ph[ShiftHour +: 5];
			wday_s2 <= (f2[2:0] == 3'd7) ? 3'd0 : f2[2:0];
		end
	end

	// stage 3: seconds within the hour
	logic [16:0] rh;
	logic [11:0] rem_s3;
	logic [4:0]  hour_s3;
	logic [2:0]  wday_s3;

	assign rh = sec_s2 - 17'(17'(hour_s2) * 17'd3600);

	always_ff @(posedge clk) begin
		if (ctl.ld[2]) begin
			rem_s3  <= rh[11:0];
			hour_s3 <= hour_s2;
			wday_s3 <= wday_s2;
		end
	end

	// stage 4: minute
	logic [26:0] pm;
	logic [11:0] rem_s4;
	logic [5:0]  min_s4;
	logic [4:0]  hour_s4;
	logic [2:0]  wday_s4;

	assign pm = 27'(rem_s3) * 27'(RecipMin);

	always_ff @(posedge clk) begin
		if (ctl.ld[3]) begin
			rem_s4  <= rem_s3;
			min_s4  <= pm[ShiftMin +: 6];
			hour_s4 <= hour_s3;
			wday_s4 <= wday_s3;
		end
	end

	// stage 5: second
	logic [11:0] rs;
	logic [5:0]  sec_s5;
	logic [5:0]  min_s5;
	logic [4:0]  hour_s5;
	logic [2:0]  wday_s5;

	assign rs = rem_s4 - 12'(12'(min_s4) * 12'd60);

	always_ff @(posedge clk) begin
		if (ctl.ld[4]) begin
			sec_s5  <= rs[5:0];
			min_s5  <= min_s4;
			hour_s5 <= hour_s4;
			wday_s5 <= wday_s4;
		end
	end

	// stages 6 and 7 only keep step with the date path
	logic [5:0] sec_s6;
	logic [5:0] min_s6;
	logic [4:0] hour_s6;
	logic [2:0] wday_s6;
	logic [5:0] sec_s7;
	logic [5:0] min_s7;
	logic [4:0] hour_s7;
	logic [2:0] wday_s7;

	always_ff @(posedge clk) begin
		if (ctl.ld[5]) begin
			sec_s6  <= sec_s5;
			min_s6  <= min_s5;
			hour_s6 <= hour_s5;
			wday_s6 <= wday_s5;
		end
		if (ctl.ld[6]) begin
			sec_s7  <= sec_s6;
			min_s7  <= min_s6;
			hour_s7 <= hour_s6;
			wday_s7 <= wday_s6;
		end
	end

	assign weekday = wday_s7;
	assign hour    = hour_s7;
	assign minute  = min_s7;
	assign second  = sec_s7;

endmodule

// ===== rtl/julian_day_to_calendar_date.sv =====
// channel | handshake               | payload
// in      | in_valid / in_ready     | day_number, seconds_of_day
// out     | out_valid / out_ready   | year, month, day_of_month, day_of_year,
//         |                         | weekday, hour, minute, second
// cfg     | cfg_wr_en               | cfg_wr_data (last julian day number)
//
// one beat per cycle in and out while the output is not stalled
// the pipeline is seven register stages, each holding at most one constant multiply
// reset empties the pipeline and sets the switch day to 2299160
// a stall holds the output beat; empty stages behind it still fill,
// so in_ready falls only when all seven stages hold a beat
module julian_day_to_calendar_date import jdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [22:0]        day_number,
	input  logic [16:0]        seconds_of_day,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] year,
	output logic [3:0]         month,
	output logic [4:0]         day_of_month,
	output logic [8:0]         day_of_year,
	output logic [2:0]         weekday,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	input  logic               cfg_wr_en,
	input  logic [22:0]        cfg_wr_data
);

	logic [22:0] switch_q;
	pipe_ctl_t   ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_q <= SwitchReset;
		end else if (cfg_wr_en) begin
			switch_q <= cfg_wr_data;
		end
	end

	jdc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	jdc_date_path u_date (
		.clk          (clk),
		.ctl          (ctl),
		.day_number   (day_number),
		.switch_day   (switch_q),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.day_of_year  (day_of_year)
	);

	jdc_time_path u_time (
		.clk            (clk),
		.ctl            (ctl),
		.day_number     (day_number),
		.seconds_of_day (seconds_of_day),
		.weekday        (weekday),
		.hour           (hour),
		.minute         (minute),
		.second         (second)
	);

endmodule

// ===== rtl/jdc_checker.sv =====
`include "assert_macros.svh"

module jdc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [14:0] year,
	input logic [3:0]        month,
	input logic [4:0]        day_of_month,
	input logic [8:0]        day_of_year,
	input logic [2:0]        weekday,
	input logic [4:0]        hour,
	input logic [5:0]        minute,
	input logic [5:0]        second
);

	// a stalled output beat holds its payload
	`JDC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month) && $stable(day_of_month) && $stable(day_of_year) && $stable(weekday) && $stable(hour) && $stable(minute) && $stable(second), "output beat changed while stalled")

	// input side may only block when the output is full and stalled
	`JDC_ASSERT(a_no_idle_block, (!out_valid || out_ready) |-> in_ready, "in_ready low while the output can drain")

	`JDC_ASSERT_RANGE(a_month_range, out_valid, month, 4'd1, 4'd12, "month out of range")

	`JDC_ASSERT_RANGE(a_mday_range, out_valid, day_of_month, 5'd1, 5'd31, "day of month out of range")

	`JDC_ASSERT(a_clock_range, out_valid |-> weekday <= 3'd6 && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59, "weekday or time of day out of range")

endmodule

bind julian_day_to_calendar_date jdc_checker u_jdc_checker (.*);

// ===== dv/tb_julian_day_to_calendar_date.sv =====
`timescale 1ns / 1ps

module tb_julian_day_to_calendar_date;
	import jdc_pkg::*;

	localparam int StallLimit = 3000;
	localparam int PhaseBeats = 230;

	typedef struct packed {
		logic [14:0] year;
		logic [3:0]  month;
		logic [4:0]  mday;
		logic [8:0]  yday;
		logic [2:0]  wday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} date_t;

	typedef struct packed {
		logic [22:0] day;
		logic [16:0] secs;
		logic        known;
		date_t       want;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [22:0]        day_number;
	logic [16:0]        seconds_of_day;
	logic               out_valid;
	logic               out_ready;
	logic signed [14:0] year;
	logic [3:0]         month;
	logic [4:0]         day_of_month;
	logic [8:0]         day_of_year;
	logic [2:0]         weekday;
	logic [4:0]         hour;
	logic [5:0]         minute;
	logic [5:0]         second;
	logic               cfg_wr_en;
	logic [22:0]        cfg_wr_data;

	logic [22:0] switch_day = SwitchReset;
	date_t       pending_dates [$];
	int          errors = 0;
	int unsigned beats_sent = 0;
	int unsigned dates_seen = 0;
	int unsigned stall_cycles = 0;
	bit          tx_lazy = 1'b0;
	bit          rx_lazy = 1'b0;

	int unsigned month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	// rows with known set carry a hand-worked date, the rest go through the predictor
	dir_row_t dir_tab [0:19] = '{
		'{23'd0,       17'd0,      1'b1, '{15'(-4712), 4'd1, 5'd1, 9'd1, 3'd1, 5'd0, 6'd0, 6'd0}},
		'{23'd0,       17'd86399,  1'b1, '{15'(-4712), 4'd1, 5'd1, 9'd1, 3'd1, 5'd23, 6'd59, 6'd59}},
		'{23'd0,       17'd131071, 1'b1, '{15'(-4712), 4'd1, 5'd1, 9'd1, 3'd1, 5'd23, 6'd59, 6'd59}},
		'{23'd2299160, 17'd43200,  1'b1, '{15'd1582, 4'd10, 5'd4, 9'd277, 3'd4, 5'd12, 6'd0, 6'd0}},
		'{23'd2299161, 17'd3661,   1'b1, '{15'd1582, 4'd10, 5'd15, 9'd288, 3'd5, 5'd1, 6'd1, 6'd1}},
		'{23'd5373484, 17'd86400,  1'b1, '{15'd9999, 4'd12, 5'd31, 9'd365, 3'd5, 5'd23, 6'd59, 6'd59}},
		'{23'h7fffff,  17'd65536,  1'b0, '0},
		'{23'd5373485, 17'd59,     1'b0, '0},
		'{23'd2451604, 17'd60,     1'b0, '0},
		'{23'd2451605, 17'd3599,   1'b0, '0},
		'{23'd2451910, 17'd3600,   1'b0, '0},
		'{23'd2415079, 17'd1,      1'b0, '0},
		'{23'd2415080, 17'd86398,  1'b0, '0},
		'{23'd2268992, 17'd7322,   1'b0, '0},
		'{23'd2268993, 17'd65535,  1'b0, '0},
		'{23'd2299159, 17'd12345,  1'b0, '0},
		'{23'd2299238, 17'd50000,  1'b0, '0},
		'{23'd1721424, 17'd30000,  1'b0, '0},
		'{23'd4194304, 17'd1,      1'b0, '0},
		'{23'd2460676, 17'd45296,  1'b0, '0}
	};

	julian_day_to_calendar_date DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.day_number     (day_number),
		.seconds_of_day (seconds_of_day),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.year           (year),
		.month          (month),
		.day_of_month   (day_of_month),
		.day_of_year    (day_of_year),
		.weekday        (weekday),
		.hour           (hour),
		.minute         (minute),
		.second         (second),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_quot(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint wrap_mod(longint n, longint d);
		return ((n % d) + d) % d;
	endfunction

	// date and time of day for one beat, under the switch day now in force
	function automatic date_t calendar_of(logic [22:0] jd, logic [16:0] secs);
		longint i, a, b, c, d, e, g, h, mday, mon, yr, yday;
		bit greg, leap;
		int unsigned s;
		date_t r;
		i = jd;
		greg = jd > switch_day;
		if (greg) begin
			a = floor_quot(4 * i - 7468865, 146097);
			b = i + 1 + a - floor_quot(a, 4);
		end else begin
			b = i;
		end
		c = b + 1524;
		d = floor_quot(20 * c - 2442, 7305);
		e = floor_quot(1461 * d, 4);
		g = floor_quot(10000 * (c - e), 306001);
		h = floor_quot(306001 * g, 10000);
		mday = c - e - h;
		mon = (g <= 13) ? g - 1 : g - 13;
		yr = (mon <= 2) ? d - 4715 : d - 4716;
		// julian rule before the switch, century rule after it
		leap = wrap_mod(yr, 4) == 0 &&
			(!greg || wrap_mod(yr, 100) != 0 || wrap_mod(yr, 400) == 0);
		yday = mday;
		if (mon >= 1 && mon <= 12)
			yday = yday + month_start[mon - 1];
		if (leap && mon > 2)
			yday = yday + 1;
		s = (secs > 17'd86399) ? 86399 : secs;
		r.year   = 15'(yr);
		r.month  = 4'(mon);
		r.mday   = 5'(mday);
		r.yday   = 9'(yday);
		r.wday   = 3'(wrap_mod(i + 1, 7));
		r.hour   = 5'(s / 3600);
		r.minute = 6'((s / 60) % 60);
		r.second = 6'(s % 60);
		return r;
	endfunction

	function automatic logic [22:0] pick_day();
		logic [22:0] r;
		int unsigned lo;
		case ($urandom_range(0, 9))
			0, 1, 2: r = 23'($urandom_range(0, 5373484));
			3, 4: begin
				// around the calendar switch
				lo = (switch_day > 800) ? switch_day - 800 : 0;
				r = 23'(lo + $urandom_range(0, 1600));
			end
			5: r = 23'($urandom);
			6: begin
				case ($urandom_range(0, 2))
					0: r = 23'($urandom_range(0, 1500));
					1: r = 23'($urandom_range(5371984, 5373484));
					default: r = 23'($urandom_range(8387107, 8388607));
				endcase
			end
			// 1900 to 2100, both century leap rules
			default: r = 23'($urandom_range(2415000, 2488070));
		endcase
		return r;
	endfunction

	function automatic logic [16:0] pick_secs();
		logic [16:0] r;
		case ($urandom_range(0, 9))
			7: begin
				case ($urandom_range(0, 5))
					0: r = 17'd0;
					1: r = 17'd59;
					2: r = 17'd60;
					3: r = 17'd3599;
					4: r = 17'd3600;
					default: r = 17'd86399;
				endcase
			end
			8: r = 17'($urandom_range(86400, 131071));
			9: r = 17'($urandom);
			default: r = 17'($urandom_range(0, 86399));
		endcase
		return r;
	endfunction

	task automatic offer_beat(logic [22:0] d, logic [16:0] s, logic known, date_t typed);
		int unsigned gap;
		if (beats_sent % 40 == 0)
			tx_lazy = $urandom_range(0, 1);
		gap = tx_lazy ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		day_number     <= d;
		seconds_of_day <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_dates.push_back(known ? typed : calendar_of(d, s));
		beats_sent++;
	endtask

	// only while the pipeline is empty
	task automatic program_switch(logic [22:0] v);
		in_valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (NumStages + 3) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		switch_day = v;
	endtask

	task automatic field_mismatch(string field, int want_v, int got_v);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
		errors++;
	endtask

	initial begin : stim
		logic [22:0] nsw;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		day_number     <= '0;
		seconds_of_day <= '0;
		cfg_wr_en      <= 1'b0;
		cfg_wr_data    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[k])
			offer_beat(dir_tab[k].day, dir_tab[k].secs, dir_tab[k].known, dir_tab[k].want);
		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				case (p)
					1: nsw = '0;
					2: nsw = 23'h7fffff;
					3: nsw = 23'd5373484;
					4: nsw = 23'($urandom_range(1, 5373483));
					default: nsw = SwitchReset;
				endcase
				program_switch(nsw);
			end
			repeat (PhaseBeats) offer_beat(pick_day(), pick_secs(), 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (NumStages + 5) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : drain
		int unsigned hold;
		date_t got, want;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (dates_seen % 40 == 0)
				rx_lazy = $urandom_range(0, 1);
			hold = rx_lazy ? $urandom_range(0, 14) : 0;
			// long back-pressure so the pipeline fills and in_ready drops
			if (dates_seen == 200 || dates_seen == 900)
				hold = 150;
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			got = '{year, month, day_of_month, day_of_year, weekday, hour, minute, second};
			if (pending_dates.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %0d-%0d-%0d", $time,
					$signed(got.year), got.month, got.mday);
				errors++;
			end else begin
				want = pending_dates.pop_front();
				if (got.year !== want.year)
					field_mismatch("year", $signed(want.year), $signed(got.year));
				if (got.month !== want.month)
					field_mismatch("month", want.month, got.month);
				if (got.mday !== want.mday)
					field_mismatch("day_of_month", want.mday, got.mday);
				if (got.yday !== want.yday)
					field_mismatch("day_of_year", want.yday, got.yday);
				if (got.wday !== want.wday)
					field_mismatch("weekday", want.wday, got.wday);
				if (got.hour !== want.hour)
					field_mismatch("hour", want.hour, got.hour);
				if (got.minute !== want.minute)
					field_mismatch("minute", want.minute, got.minute);
				if (got.second !== want.second)
					field_mismatch("second", want.second, got.second);
			end
			dates_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == StallLimit) begin
			$display("%0t: no beat moved for %0d cycles", $time, StallLimit);
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

// ===== julian_day_to_calendar_date.f =====
+incdir+rtl
rtl/jdc_pkg.sv
rtl/jdc_pipe_ctrl.sv
rtl/jdc_date_path.sv
rtl/jdc_time_path.sv
rtl/julian_day_to_calendar_date.sv
rtl/jdc_checker.sv
dv/tb_julian_day_to_calendar_date.sv
